// File: design/smacc_pkg.sv
// ----------------------------------------------------------------------------
// smacc_pkg
// Shared types and constants for the sign-magnitude accumulator machine.
// ----------------------------------------------------------------------------
package smacc_pkg;

  localparam int MAX_WORD   = 16;
  localparam int ROT_BITS   = 6;   // holds a rotate amount below 3*MAX_WORD
  localparam int CMD_DEPTH  = 4;
  localparam int RES_DEPTH  = 2;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_SAVE  = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_CYCLE = 3'd3;

  localparam logic [1:0] REG_NONE  = 2'd0;
  localparam logic [1:0] REG_ONE   = 2'd1;
  localparam logic [1:0] REG_TWO   = 2'd2;
  localparam logic [1:0] REG_THREE = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               is_register;
    logic [1:0]         reg_number;
    logic signed [15:0] constant;
  } smacc_in_t;

  typedef struct packed {
    logic [15:0] acc_value;
    logic [15:0] r1_value;
    logic [15:0] r2_value;
    logic [15:0] r3_value;
    logic        negative_flag;
    logic [15:0] program_count;
  } smacc_out_t;

  // Decoded instruction handed from the front end to the execute side.
  typedef struct packed {
    logic [2:0]          op;
    logic                use_reg;
    logic [1:0]          reg_sel;
    logic [MAX_WORD-1:0] operand;   // constant already in sign-magnitude form
    logic [ROT_BITS-1:0] rot_left;  // left rotate amount, 0 .. 3*WORD_BITS-1
  } smacc_cmd_t;

endpackage

// File: design/sign_magnitude_accumulator_cpu.sv
// ----------------------------------------------------------------------------
// sign_magnitude_accumulator_cpu
// Accumulator machine with three registers, sign-magnitude words.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle while in_full is low and returns one
// state snapshot word per instruction, in order. A pushed word passes the
// decode register (constant conversion and the reciprocal multiply that
// reduces a rotate count modulo 3*WORD_BITS), then a four-word command
// queue, then the execute stage that updates the state; results wait in a
// two-word queue whose head drives out_data. So a stalled reader does not
// stop the input until both queues fill. Sustained rate is one instruction
// per cycle while the reader keeps up, set by the execute loop on the
// state. Registers are WORD_BITS wide and zero-extended on the 16-bit
// result fields.
// ----------------------------------------------------------------------------
module sign_magnitude_accumulator_cpu
  import smacc_pkg::*;
#(
  parameter int WORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  smacc_in_t  in_data,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output smacc_out_t out_data
);

  smacc_cmd_t cmd_wr, cmd_rd;
  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  smacc_out_t res_wr;
  logic       res_push, res_full;

  smacc_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_full)
  );

  smacc_fifo #(.T(smacc_cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  smacc_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_wr),
    .res_full  (res_full)
  );

  smacc_fifo #(.T(smacc_out_t), .DEPTH(RES_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

// File: design/smacc_fifo.sv
// ----------------------------------------------------------------------------
// smacc_fifo
// Small register queue with a combinational head read.
// ----------------------------------------------------------------------------
module smacc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wr_data,
  output logic full,
  input  logic pop,
  output T     rd_data,
  output logic empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  T                    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/smacc_front.sv
// ----------------------------------------------------------------------------
// smacc_front
// Decode stage: converts the constant to sign-magnitude and reduces it to a
// left rotate amount modulo 3*WORD_BITS.
// ----------------------------------------------------------------------------
module smacc_front
  import smacc_pkg::*;
#(
  parameter int WORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  smacc_in_t  in_data,
  output logic       in_full,
  output logic       cmd_push,
  output smacc_cmd_t cmd_data,
  input  logic       cmd_full
);

  localparam int TOTAL = 3 * WORD_BITS;
  // ceil(2^32 / TOTAL); exact quotient for any 16-bit dividend
  localparam logic [29:0] RECIP = 30'(((64'd1 << 32) / TOTAL) + 1);

  logic        s1_valid_r;
  logic [2:0]  s1_op_r;
  logic        s1_use_reg_r;
  logic [1:0]  s1_reg_r;
  logic        s1_neg_r;
  logic [15:0] s1_abs_r;
  logic [13:0] s1_quot_r;

  logic        advance;
  logic        neg;
  logic [15:0] abs_val;
  logic [45:0] prod;
  logic [15:0] rem_full;
  logic [ROT_BITS-1:0] rem;
  logic [ROT_BITS-1:0] rot_left;

  assign advance = !s1_valid_r || !cmd_full;
  assign in_full = !advance;

  assign neg     = in_data.constant[15];
  assign abs_val = neg ? 16'(-in_data.constant) : 16'(in_data.constant);
  assign prod    = 46'(abs_val) * 46'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r      <= in_data.opcode;
      s1_use_reg_r <= in_data.is_register;
      s1_reg_r     <= in_data.reg_number;
      s1_neg_r     <= neg;
      s1_abs_r     <= abs_val;
      s1_quot_r    <= prod[45:32];
    end
  end

  // remainder and conversion of a right rotate into a left one
  always_comb begin
    rem_full = s1_abs_r - 16'(s1_quot_r * 16'(TOTAL));
    rem      = rem_full[ROT_BITS-1:0];
    if (s1_neg_r && rem != '0) begin
      rot_left = ROT_BITS'(TOTAL) - rem;
    end else begin
      rot_left = rem;
    end
  end

  assign cmd_push          = s1_valid_r;
  assign cmd_data.op       = s1_op_r;
  assign cmd_data.use_reg  = s1_use_reg_r;
  assign cmd_data.reg_sel  = s1_reg_r;
  assign cmd_data.operand  = MAX_WORD'({s1_neg_r, s1_abs_r[WORD_BITS-2:0]});
  assign cmd_data.rot_left = rot_left;

endmodule

// File: design/smacc_back.sv
// ----------------------------------------------------------------------------
// smacc_back
// Execute stage: holds the machine state and retires one decoded instruction
// per cycle unless cmd_empty or res_full, pushing a state snapshot for each.
// ----------------------------------------------------------------------------
module smacc_back
  import smacc_pkg::*;
#(
  parameter int WORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  smacc_cmd_t cmd_data,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       res_push,
  output smacc_out_t res_data,
  input  logic       res_full
);

  localparam int TOTAL = 3 * WORD_BITS;
  localparam int MAG   = WORD_BITS - 1;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] r1_r, r1_nxt;
  logic [WORD_BITS-1:0] r2_r, r2_nxt;
  logic [WORD_BITS-1:0] r3_r, r3_nxt;
  logic [WORD_BITS-1:0] cnt_r, cnt_nxt;

  logic                 go;
  logic                 reg_ok;
  logic [WORD_BITS-1:0] reg_val;
  logic [WORD_BITS-1:0] opnd;
  logic [WORD_BITS-1:0] sum;
  logic                 sa, sb;
  logic [MAG-1:0]       ma, mb;
  logic [TOTAL-1:0]     cat;
  logic [TOTAL-1:0]     rotated;

  assign go      = !cmd_empty && !res_full;
  assign cmd_pop = go;

  always_comb begin
    case (cmd_data.reg_sel)
      REG_ONE:   reg_val = r1_r;
      REG_TWO:   reg_val = r2_r;
      REG_THREE: reg_val = r3_r;
      default:   reg_val = '0;
    endcase
  end

  assign reg_ok = (cmd_data.reg_sel != REG_NONE);
  assign opnd   = cmd_data.use_reg ? reg_val : cmd_data.operand[WORD_BITS-1:0];

  // sign-magnitude add; carry out of the magnitude is dropped
  always_comb begin
    sa = acc_r[WORD_BITS-1];
    sb = opnd[WORD_BITS-1];
    ma = acc_r[MAG-1:0];
    mb = opnd[MAG-1:0];
    if (sa == sb) begin
      sum = {sa, MAG'(ma + mb)};
    end else if (ma == mb) begin
      sum = '0;
    end else if (ma < mb) begin
      sum = {sb, MAG'(mb - ma)};
    end else begin
      sum = {sa, MAG'(ma - mb)};
    end
  end

  assign cat     = {r3_r, r2_r, r1_r};
  assign rotated = TOTAL'(({cat, cat} << cmd_data.rot_left) >> TOTAL);

  always_comb begin
    acc_nxt = acc_r;
    r1_nxt  = r1_r;
    r2_nxt  = r2_r;
    r3_nxt  = r3_r;
    cnt_nxt = cnt_r;
    if (go) begin
      cnt_nxt = cnt_r + 1'b1;
      case (cmd_data.op)
        OP_LOAD: begin
          if (!cmd_data.use_reg || reg_ok) begin
            acc_nxt = opnd;
          end
        end
        OP_SAVE: begin
          if (cmd_data.use_reg) begin
            case (cmd_data.reg_sel)
              REG_ONE:   r1_nxt = acc_r;
              REG_TWO:   r2_nxt = acc_r;
              REG_THREE: r3_nxt = acc_r;
              default:   ;
            endcase
          end
        end
        OP_ADD: begin
          if (!cmd_data.use_reg || reg_ok) begin
            acc_nxt = sum;
          end
        end
        OP_CYCLE: begin
          r1_nxt = rotated[WORD_BITS-1:0];
          r2_nxt = rotated[2*WORD_BITS-1:WORD_BITS];
          r3_nxt = rotated[TOTAL-1:2*WORD_BITS];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      r1_r  <= '0;
      r2_r  <= '0;
      r3_r  <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      r3_r  <= r3_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res_push               = go;
  assign res_data.acc_value     = 16'(acc_nxt);
  assign res_data.r1_value      = 16'(r1_nxt);
  assign res_data.r2_value      = 16'(r2_nxt);
  assign res_data.r3_value      = 16'(r3_nxt);
  assign res_data.negative_flag = acc_nxt[WORD_BITS-1];
  assign res_data.program_count = 16'(cnt_nxt);

endmodule

// File: tb/sv/sign_magnitude_accumulator_cpu_test.sv
// ----------------------------------------------------------------------------
// sign_magnitude_accumulator_cpu_test
// Self-checking bench for the sign-magnitude accumulator machine.
// ----------------------------------------------------------------------------
// A driver pushes instruction words from a pending queue in random bursts.
// Every accepted word is executed on a local copy of the machine state, and
// the resulting state snapshot is queued. A monitor pops snapshots under a
// shifting stall pattern, with two long hold-offs that back the block up,
// and compares each field against the oldest queued snapshot.
// ----------------------------------------------------------------------------
module sign_magnitude_accumulator_cpu_test;
  import smacc_pkg::*;

  localparam int         ROT_SPAN    = 48;       // {R3,R2,R1} width
  localparam int         RAND_ITEMS  = 600;
  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [2:0] OP_NOP_LO   = 3'd4;     // 4..7 only bump the counter
  localparam logic [2:0] OP_NOP_HI   = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  smacc_in_t  in_data = '0;
  logic       in_full;
  logic       out_empty;
  logic       out_pop = 1'b0;
  smacc_out_t out_data;

  sign_magnitude_accumulator_cpu u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // machine state as predicted
  logic [15:0] acc_q = '0;
  logic [15:0] gpr [1:3] = '{default: '0};
  logic        neg_q = 1'b0;
  logic [15:0] pc_q = '0;

  smacc_in_t  instr_queue [$];
  smacc_out_t snapshots_due [$];
  int         errors = 0;
  int         cycles = 0;
  bit         took_word = 1'b0;

  function automatic logic [15:0] to_sm(logic [15:0] c);
    logic [15:0] mag;
    mag = c[15] ? (16'd0 - c) : c;
    return {c[15], mag[14:0]};
  endfunction

  function automatic logic [15:0] sm_sum(logic [15:0] a, logic [15:0] b);
    logic [14:0] mag;
    if (a[15] == b[15]) begin
      mag = a[14:0] + b[14:0];   // magnitude carry dropped
      return {a[15], mag};
    end
    if (a[14:0] == b[14:0]) return 16'h0000;
    if (a[14:0] < b[14:0]) return {b[15], b[14:0] - a[14:0]};
    return {a[15], a[14:0] - b[14:0]};
  endfunction

  function automatic void spin_regs(logic [15:0] c);
    int          left;
    int          amt;
    logic [47:0] cat;
    if (c[15]) begin
      amt = (32'h10000 - c) % ROT_SPAN;
      left = (amt == 0) ? 0 : ROT_SPAN - amt;
    end else begin
      left = c % ROT_SPAN;
    end
    if (left != 0) begin
      cat = {gpr[REG_THREE], gpr[REG_TWO], gpr[REG_ONE]};
      cat = (cat << left) | (cat >> (ROT_SPAN - left));
      gpr[REG_ONE]   = cat[15:0];
      gpr[REG_TWO]   = cat[31:16];
      gpr[REG_THREE] = cat[47:32];
    end
  endfunction

  function automatic smacc_out_t execute_instr(smacc_in_t w);
    smacc_out_t snap;
    case (w.opcode)
      OP_LOAD: begin
        if (!w.is_register) acc_q = to_sm(w.constant);
        else if (w.reg_number != REG_NONE) acc_q = gpr[w.reg_number];
      end
      OP_SAVE: begin
        if (w.is_register && w.reg_number != REG_NONE) gpr[w.reg_number] = acc_q;
      end
      OP_ADD: begin
        if (!w.is_register) acc_q = sm_sum(acc_q, to_sm(w.constant));
        else if (w.reg_number != REG_NONE) acc_q = sm_sum(acc_q, gpr[w.reg_number]);
      end
      OP_CYCLE: spin_regs(w.constant);
      default: ;
    endcase
    neg_q = acc_q[15];
    pc_q  = pc_q + 16'd1;
    snap.acc_value     = acc_q;
    snap.r1_value      = gpr[REG_ONE];
    snap.r2_value      = gpr[REG_TWO];
    snap.r3_value      = gpr[REG_THREE];
    snap.negative_flag = neg_q;
    snap.program_count = pc_q;
    return snap;
  endfunction

  function automatic smacc_in_t mk(logic [2:0] op, logic isreg, logic [1:0] rn, int c);
    smacc_in_t w;
    w.opcode      = op;
    w.is_register = isreg;
    w.reg_number  = rn;
    w.constant    = c[15:0];
    return w;
  endfunction

  function automatic smacc_in_t rand_instr();
    smacc_in_t w;
    int        pick;
    int        c;
    pick = $urandom_range(0, 99);
    if (pick < 25) w.opcode = OP_LOAD;
    else if (pick < 45) w.opcode = OP_SAVE;
    else if (pick < 75) w.opcode = OP_ADD;
    else if (pick < 92) w.opcode = OP_CYCLE;
    else w.opcode = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
    w.is_register = 1'($urandom_range(0, 1));
    w.reg_number  = ($urandom_range(0, 7) == 0) ? REG_NONE :
                    2'($urandom_range(REG_ONE, REG_THREE));
    case ($urandom_range(0, 3))
      0: c = $urandom;
      1: c = $urandom_range(0, 60);
      2: begin
        case ($urandom_range(0, 5))
          0: c = -32768;
          1: c = 32767;
          2: c = -1;
          3: c = 0;
          4: c = ROT_SPAN;
          default: c = -ROT_SPAN;
        endcase
      end
      default: c = $urandom_range(0, 32767);
    endcase
    if ($urandom_range(0, 1) == 1) c = -c;
    w.constant = c[15:0];
    return w;
  endfunction

  // accept side: predict on every word the block takes
  always @(posedge clk) begin
    took_word = rst_n && in_push && !in_full;
    if (took_word) snapshots_due.push_back(execute_instr(in_data));
  end

  // driver: bursts of offers with idle gaps in between
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (took_word) void'(instr_queue.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (instr_queue.size() != 0) begin
        in_push <= 1'b1;
        in_data <= instr_queue[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver: stall pattern steps through four modes, plus two long hold-offs
  int rx_cycle = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == 150 || rx_cycle == 1500) hold_left = 90;
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case ((rx_cycle >> 7) & 3)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= (rx_cycle % 5 == 0);
          default: out_pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor
  smacc_out_t want;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (snapshots_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        want = snapshots_due.pop_front();
        if (out_data.acc_value !== want.acc_value) begin
          $display("%0t: acc exp %h got %h", $time, want.acc_value, out_data.acc_value);
          errors++;
        end
        if (out_data.r1_value !== want.r1_value) begin
          $display("%0t: r1 exp %h got %h", $time, want.r1_value, out_data.r1_value);
          errors++;
        end
        if (out_data.r2_value !== want.r2_value) begin
          $display("%0t: r2 exp %h got %h", $time, want.r2_value, out_data.r2_value);
          errors++;
        end
        if (out_data.r3_value !== want.r3_value) begin
          $display("%0t: r3 exp %h got %h", $time, want.r3_value, out_data.r3_value);
          errors++;
        end
        if (out_data.negative_flag !== want.negative_flag) begin
          $display("%0t: neg exp %b got %b", $time, want.negative_flag,
                   out_data.negative_flag);
          errors++;
        end
        if (out_data.program_count !== want.program_count) begin
          $display("%0t: pc exp %h got %h", $time, want.program_count,
                   out_data.program_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // directed: constant extremes, add corner cases, null operands, rotates
    instr_queue.push_back(mk(OP_LOAD, 1'b0, REG_NONE, 32767));
    instr_queue.push_back(mk(OP_ADD, 1'b0, REG_NONE, 1));         // carry dropped
    instr_queue.push_back(mk(OP_LOAD, 1'b0, REG_NONE, -32768));   // minus zero
    instr_queue.push_back(mk(OP_SAVE, 1'b1, REG_ONE, 0));
    instr_queue.push_back(mk(OP_ADD, 1'b0, REG_NONE, 0));         // -0 + +0
    instr_queue.push_back(mk(OP_LOAD, 1'b0, REG_NONE, -1));
    instr_queue.push_back(mk(OP_ADD, 1'b0, REG_NONE, -32767));    // negative zero kept
    instr_queue.push_back(mk(OP_LOAD, 1'b0, REG_NONE, -5));
    instr_queue.push_back(mk(OP_ADD, 1'b0, REG_NONE, 3));
    instr_queue.push_back(mk(OP_ADD, 1'b0, REG_NONE, 7));
    instr_queue.push_back(mk(OP_SAVE, 1'b1, REG_TWO, 0));
    instr_queue.push_back(mk(OP_SAVE, 1'b0, REG_THREE, -1));      // constant save ignored
    instr_queue.push_back(mk(OP_SAVE, 1'b1, REG_NONE, 0));
    instr_queue.push_back(mk(OP_LOAD, 1'b1, REG_NONE, 0));
    instr_queue.push_back(mk(OP_ADD, 1'b1, REG_NONE, 0));
    instr_queue.push_back(mk(OP_LOAD, 1'b1, REG_ONE, 0));
    instr_queue.push_back(mk(OP_ADD, 1'b1, REG_TWO, 0));
    instr_queue.push_back(mk(OP_SAVE, 1'b1, REG_THREE, 0));
    instr_queue.push_back(mk(OP_CYCLE, 1'b0, REG_NONE, 1));
    instr_queue.push_back(mk(OP_CYCLE, 1'b0, REG_NONE, -1));
    instr_queue.push_back(mk(OP_CYCLE, 1'b0, REG_NONE, 0));
    instr_queue.push_back(mk(OP_CYCLE, 1'b0, REG_NONE, ROT_SPAN));
    instr_queue.push_back(mk(OP_CYCLE, 1'b0, REG_NONE, -32768));
    instr_queue.push_back(mk(OP_CYCLE, 1'b1, REG_TWO, 32767));    // is_register ignored
    instr_queue.push_back(mk(OP_NOP_LO, 1'b1, REG_ONE, -1));
    instr_queue.push_back(mk(OP_NOP_HI, 1'b0, REG_THREE, 32767));
    repeat (RAND_ITEMS) instr_queue.push_back(rand_instr());

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (instr_queue.size() == 0);
    wait (snapshots_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sign_magnitude_accumulator_cpu.f
design/smacc_pkg.sv
design/smacc_fifo.sv
design/smacc_front.sv
design/smacc_back.sv
design/sign_magnitude_accumulator_cpu.sv
tb/sv/sign_magnitude_accumulator_cpu_test.sv
